/* rtl/ims_pkg.sv */
package ims_pkg;

    localparam int unsigned REG_WIDTH   = 16;
    localparam int unsigned INDEX_WIDTH = 2;
    localparam int unsigned LED_COUNT   = 4;

    localparam logic [REG_WIDTH-1:0] HOLD_RESET = 16'd500;

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_OFF_DELAY  = 2'd0,
        REG_ARM_HOLD   = 2'd1,
        REG_CLEAR_HOLD = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_ALL_OFF = 2'd0,
        MODE_WAIT    = 2'd1,
        MODE_RUN     = 2'd2,
        MODE_ERROR   = 2'd3
    } mode_t;

    // LED bit positions inside the held LED vector
    localparam int unsigned LED_ONE   = 0;
    localparam int unsigned LED_TWO   = 1;
    localparam int unsigned LED_THREE = 2;
    localparam int unsigned LED_FOUR  = 3;

    typedef struct packed {
        logic [REG_WIDTH-1:0] off_delay_ticks;
        logic [REG_WIDTH-1:0] arm_hold_ticks;
        logic [REG_WIDTH-1:0] clear_hold_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t                mode;
        logic                 fault_latched;
        logic                 pwm_on;
        logic [LED_COUNT-1:0] leds;
    } ctrl_t;

endpackage

/* rtl/ims_if.sv */
interface ims_in_if;
    logic valid;
    logic ready;
    logic run_switch;
    logic reset_switch;
    logic fault_event;

    modport source (output valid, output run_switch, output reset_switch,
                    output fault_event, input ready);
    modport sink   (input valid, input run_switch, input reset_switch,
                    input fault_event, output ready);
endinterface

interface ims_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       pwm_enable;
    logic       led_one;
    logic       led_two;
    logic       led_three;
    logic       led_four;

    modport source (output valid, output mode, output pwm_enable, output led_one,
                    output led_two, output led_three, output led_four, input ready);
    modport sink   (input valid, input mode, input pwm_enable, input led_one,
                    input led_two, input led_three, input led_four, output ready);
endinterface

/* rtl/inverter_mode_supervisor.sv */
// A result is registered: it is valid in the cycle after its tick request is accepted.
// Throughput: one tick per cycle while the output is not stalled; the mode and counter update is combinational.
// A new request is taken in the same cycle the pending result is taken.
// Reset clears mode (all-off), fault latch, counters, PWM enable and LEDs,
// and loads all three hold registers with 500.
module inverter_mode_supervisor #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ims_pkg::INDEX_WIDTH-1:0]   cfg_index,
    input  logic [ims_pkg::REG_WIDTH-1:0]     cfg_data,
    ims_in_if.sink                            in_ch,
    ims_out_if.source                         out_ch
);

    ims_pkg::cfg_t          cfg_reg;
    ims_pkg::ctrl_t         ctrl_reg, ctrl_next;
    logic [COUNT_WIDTH-1:0] off_cnt_reg, off_cnt_next;
    logic [COUNT_WIDTH-1:0] arm_cnt_reg, arm_cnt_next;
    logic [COUNT_WIDTH-1:0] clear_cnt_reg, clear_cnt_next;
    logic                   out_valid_reg;
    logic                   in_take;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_delay_ticks  <= ims_pkg::HOLD_RESET;
            cfg_reg.arm_hold_ticks   <= ims_pkg::HOLD_RESET;
            cfg_reg.clear_hold_ticks <= ims_pkg::HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ims_pkg::REG_OFF_DELAY:  cfg_reg.off_delay_ticks  <= cfg_data;
                ims_pkg::REG_ARM_HOLD:   cfg_reg.arm_hold_ticks   <= cfg_data;
                ims_pkg::REG_CLEAR_HOLD: cfg_reg.clear_hold_ticks <= cfg_data;
                default:                 cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    ims_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .cfg            (cfg_reg),
        .ctrl           (ctrl_reg),
        .off_cnt        (off_cnt_reg),
        .arm_cnt        (arm_cnt_reg),
        .clear_cnt      (clear_cnt_reg),
        .run_switch     (in_ch.run_switch),
        .reset_switch   (in_ch.reset_switch),
        .fault_event    (in_ch.fault_event),
        .ctrl_next      (ctrl_next),
        .off_cnt_next   (off_cnt_next),
        .arm_cnt_next   (arm_cnt_next),
        .clear_cnt_next (clear_cnt_next)
    );

    // state doubles as the result register: it only moves on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.mode          <= ims_pkg::MODE_ALL_OFF;
            ctrl_reg.fault_latched <= 1'b0;
            ctrl_reg.pwm_on        <= 1'b0;
            ctrl_reg.leds          <= '0;
            off_cnt_reg            <= '0;
            arm_cnt_reg            <= '0;
            clear_cnt_reg          <= '0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                ctrl_reg      <= ctrl_next;
                off_cnt_reg   <= off_cnt_next;
                arm_cnt_reg   <= arm_cnt_next;
                clear_cnt_reg <= clear_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.mode       = ctrl_reg.mode;
    assign out_ch.pwm_enable = ctrl_reg.pwm_on;
    assign out_ch.led_one    = ctrl_reg.leds[ims_pkg::LED_ONE];
    assign out_ch.led_two    = ctrl_reg.leds[ims_pkg::LED_TWO];
    assign out_ch.led_three  = ctrl_reg.leds[ims_pkg::LED_THREE];
    assign out_ch.led_four   = ctrl_reg.leds[ims_pkg::LED_FOUR];

    a_pwm_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.pwm_on |-> (ctrl_reg.mode == ims_pkg::MODE_RUN))
        else $error("PWM enabled outside run mode");

    a_no_fault_in_all_off: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.mode == ims_pkg::MODE_ALL_OFF) |-> !ctrl_reg.fault_latched)
        else $error("fault latch set in all-off mode");

    a_led_two_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ctrl_reg.leds[ims_pkg::LED_TWO] ==
            ((ctrl_reg.mode == ims_pkg::MODE_ALL_OFF) ||
             (ctrl_reg.mode == ims_pkg::MODE_RUN))))
        else $error("LED two does not match mode");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(ctrl_reg)))
        else $error("pending result changed while stalled");

endmodule

/* rtl/ims_step.sv */
module ims_step #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  ims_pkg::cfg_t           cfg,
    input  ims_pkg::ctrl_t          ctrl,
    input  logic [COUNT_WIDTH-1:0]  off_cnt,
    input  logic [COUNT_WIDTH-1:0]  arm_cnt,
    input  logic [COUNT_WIDTH-1:0]  clear_cnt,
    input  logic                    run_switch,
    input  logic                    reset_switch,
    input  logic                    fault_event,
    output ims_pkg::ctrl_t          ctrl_next,
    output logic [COUNT_WIDTH-1:0]  off_cnt_next,
    output logic [COUNT_WIDTH-1:0]  arm_cnt_next,
    output logic [COUNT_WIDTH-1:0]  clear_cnt_next
);

    localparam int unsigned CW = (COUNT_WIDTH > ims_pkg::REG_WIDTH) ?
                                 COUNT_WIDTH : ims_pkg::REG_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [CW-1:0]          off_ext, arm_ext, clear_ext;
    logic [CW-1:0]          off_lim, arm_lim, clear_lim;
    logic [COUNT_WIDTH-1:0] off_inc, arm_inc, clear_inc;
    logic [CW-1:0]          arm_inc_ext, clear_inc_ext;
    logic                   fault_now;
    logic [ims_pkg::LED_COUNT-1:0] leds;

    assign off_ext   = CW'(off_cnt);
    assign arm_ext   = CW'(arm_cnt);
    assign clear_ext = CW'(clear_cnt);
    assign off_lim   = CW'(cfg.off_delay_ticks);
    assign arm_lim   = CW'(cfg.arm_hold_ticks);
    assign clear_lim = CW'(cfg.clear_hold_ticks);

    // saturating increments
    assign off_inc   = (off_cnt == CNT_MAX)   ? off_cnt   : off_cnt + 1'b1;
    assign arm_inc   = (arm_cnt == CNT_MAX)   ? arm_cnt   : arm_cnt + 1'b1;
    assign clear_inc = (clear_cnt == CNT_MAX) ? clear_cnt : clear_cnt + 1'b1;
    assign arm_inc_ext   = CW'(arm_inc);
    assign clear_inc_ext = CW'(clear_inc);

    assign fault_now = ctrl.fault_latched | fault_event;

    always_comb
    begin
        ctrl_next               = ctrl;
        ctrl_next.fault_latched = fault_now;
        off_cnt_next            = off_cnt;
        arm_cnt_next            = arm_cnt;
        clear_cnt_next          = clear_cnt;

        unique case (ctrl.mode)
            ims_pkg::MODE_ALL_OFF:
            begin
                // a fault seen here is dropped
                ctrl_next.pwm_on        = 1'b0;
                ctrl_next.fault_latched = 1'b0;
                if (off_ext >= off_lim)
                begin
                    ctrl_next.mode = ims_pkg::MODE_WAIT;
                    off_cnt_next   = '0;
                end
                else
                begin
                    off_cnt_next = off_inc;
                end
            end
            ims_pkg::MODE_WAIT:
            begin
                priority if (fault_now)
                begin
                    ctrl_next.pwm_on = 1'b0;
                    ctrl_next.mode   = ims_pkg::MODE_ERROR;
                end
                else if (run_switch && (arm_ext >= arm_lim))
                begin
                    arm_cnt_next     = '0;
                    ctrl_next.pwm_on = 1'b1;
                    ctrl_next.mode   = ims_pkg::MODE_RUN;
                end
                else if (!run_switch)
                begin
                    // clamp to the hold value; it fits since it is below the increment
                    arm_cnt_next = (arm_inc_ext >= arm_lim) ? arm_lim[COUNT_WIDTH-1:0]
                                                            : arm_inc;
                end
                else
                begin
                    arm_cnt_next = '0;
                end
            end
            ims_pkg::MODE_RUN:
            begin
                priority if (fault_now)
                begin
                    ctrl_next.pwm_on = 1'b0;
                    ctrl_next.mode   = ims_pkg::MODE_ERROR;
                end
                else if (!run_switch)
                begin
                    ctrl_next.pwm_on = 1'b0;
                    ctrl_next.mode   = ims_pkg::MODE_WAIT;
                end
                else
                begin
                    ctrl_next.pwm_on = ctrl.pwm_on;
                end
            end
            ims_pkg::MODE_ERROR:
            begin
                priority if (reset_switch && (clear_ext >= clear_lim))
                begin
                    clear_cnt_next          = '0;
                    ctrl_next.fault_latched = 1'b0;
                    ctrl_next.mode          = ims_pkg::MODE_ALL_OFF;
                end
                else if (!reset_switch)
                begin
                    clear_cnt_next = (clear_inc_ext >= clear_lim) ?
                                     clear_lim[COUNT_WIDTH-1:0] : clear_inc;
                end
                else
                begin
                    clear_cnt_next = clear_cnt;
                end
            end
            default:
            begin
                ctrl_next.mode = ctrl.mode;
            end
        endcase

        // LEDs follow the new mode, some bits hold
        leds = ctrl.leds;
        unique case (ctrl_next.mode)
            ims_pkg::MODE_ALL_OFF:
            begin
                leds[ims_pkg::LED_ONE]   = 1'b1;
                leds[ims_pkg::LED_TWO]   = 1'b1;
                leds[ims_pkg::LED_THREE] = 1'b1;
                leds[ims_pkg::LED_FOUR]  = 1'b0;
            end
            ims_pkg::MODE_WAIT:
            begin
                leds[ims_pkg::LED_TWO]   = 1'b0;
                leds[ims_pkg::LED_THREE] = 1'b0;
                leds[ims_pkg::LED_FOUR]  = 1'b0;
            end
            ims_pkg::MODE_RUN:
            begin
                leds[ims_pkg::LED_TWO]   = 1'b1;
                leds[ims_pkg::LED_THREE] = 1'b0;
            end
            ims_pkg::MODE_ERROR:
            begin
                leds[ims_pkg::LED_TWO]   = 1'b0;
                leds[ims_pkg::LED_FOUR]  = 1'b1;
            end
            default:
            begin
                leds = ctrl.leds;
            end
        endcase
        ctrl_next.leds = leds;
    end

endmodule
